>>> hdl/pmc_pkg.sv
// Shared types and constants for the palindrome min-cut block.
package pmc_pkg;

   localparam int PMC_MAX_LEN     = 1024;
   localparam int PMC_QUEUE_DEPTH = 2;
   localparam int SYM_W           = 8;
   localparam int CUTS_W          = 10;
   localparam logic [CUTS_W-1:0] CUTS_MAX = 10'd1023;

   // Classified request from the front end to the back end.
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             too_long;
   } cmd_type;

   // One result as it waits in the result queue.
   typedef struct packed {
      logic [CUTS_W-1:0] prefix_min_cuts;
      logic              end_of_string;
      logic              too_long;
   } rsp_type;

   // Queue flags seen by the back end.
   typedef struct packed {
      logic cmd_empty;
      logic rsp_full;
   } queue_status_type;

   // Queue strobes driven by the back end.
   typedef struct packed {
      logic cmd_pop;
      logic rsp_push;
   } back_ctl_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SWEEP,
      BK_DRAIN,
      BK_FINISH
   } back_state_type;

endpackage

>>> hdl/pmc_ram.sv
// Generic simple dual-port RAM with registered read.
module pmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> hdl/pmc_fifo.sv
// Small register-based queue with first-word fall-through read.
module pmc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/pmc_front.sv
// Front end: accept requests, track string length, flag overlong symbols.
module pmc_front #(
   parameter int MAX_LEN = pmc_pkg::PMC_MAX_LEN
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  logic                     queue_full,
   input  logic [pmc_pkg::SYM_W-1:0] symbol,
   input  logic                     last,
   output logic                     cmd_push,
   output pmc_pkg::cmd_type         cmd
);

   localparam int LW = $clog2(MAX_LEN + 1);

   logic [LW-1:0] len_ff, len_in;
   logic          too_long;

   assign too_long     = (len_ff == LW'(MAX_LEN));
   assign cmd_push     = req_push && !queue_full;
   assign cmd.symbol   = symbol;
   assign cmd.last     = last;
   assign cmd.too_long = too_long;

   always_comb begin
      len_in = len_ff;
      if (cmd_push) begin
         if (last) begin
            len_in = '0;
         end else if (!too_long) begin
            len_in = len_ff + LW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

endmodule

>>> hdl/pmc_back.sv
// Back end: sweep the stored prefix for each symbol and build the result.
module pmc_back #(
   parameter int MAX_LEN = pmc_pkg::PMC_MAX_LEN
) (
   input  logic                      clock,
   input  logic                      reset,
   input  pmc_pkg::queue_status_type q_status,
   input  pmc_pkg::cmd_type          cmd,
   output pmc_pkg::back_ctl_type     ctl,
   output pmc_pkg::rsp_type          rsp
);

   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int IW = $clog2(MAX_LEN);
   localparam int CW = (LW > pmc_pkg::CUTS_W) ? LW : pmc_pkg::CUTS_W;

   pmc_pkg::back_state_type state_ff, state_in;

   logic [LW-1:0]                len_ff, len_in;
   logic [pmc_pkg::CUTS_W-1:0]   held_ff, held_in;
   logic [pmc_pkg::SYM_W-1:0]    sym_ff, sym_in;
   logic                         last_ff, last_in;
   logic                         tl_ff, tl_in;
   logic [IW-1:0]                i_ff, i_in;
   logic [LW-1:0]                best_ff, best_in;
   logic                         b_valid_ff, b_valid_in;
   logic [IW-1:0]                b_i_ff;

   logic [IW-1:0]                j;
   logic                         rd_en, sym_we, parts_we, pal_we, pal_bit;
   logic [pmc_pkg::SYM_W-1:0]    sym_rd;
   logic                         pal_rd;
   logic [LW-1:0]                parts_rd, cand;
   logic [IW-1:0]                span;
   logic [LW-1:0]                cuts_raw;
   logic [CW-1:0]                cuts_ext;
   logic [pmc_pkg::CUTS_W-1:0]   cuts_sat;

   assign j = len_ff[IW-1:0];

   pmc_ram #(.WIDTH(pmc_pkg::SYM_W), .DEPTH(MAX_LEN)) u_sym_ram (
      .clock   (clock),
      .wr_en   (sym_we),
      .wr_addr (j),
      .wr_data (cmd.symbol),
      .rd_en   (rd_en),
      .rd_addr (i_ff),
      .rd_data (sym_rd)
   );

   // Read the inner bit one position ahead of the write, so it is still the previous column.
   pmc_ram #(.WIDTH(1), .DEPTH(MAX_LEN)) u_pal_ram (
      .clock   (clock),
      .wr_en   (pal_we),
      .wr_addr (b_i_ff),
      .wr_data (pal_bit),
      .rd_en   (rd_en),
      .rd_addr (IW'(i_ff + IW'(1))),
      .rd_data (pal_rd)
   );

   pmc_ram #(.WIDTH(LW), .DEPTH(MAX_LEN + 1)) u_parts_ram (
      .clock   (clock),
      .wr_en   (parts_we),
      .wr_addr (LW'(len_ff + LW'(1))),
      .wr_data (best_ff),
      .rd_en   (rd_en),
      .rd_addr (LW'(i_ff)),
      .rd_data (parts_rd)
   );

   // Sweep stage: ends match and the inside is short or a palindrome.
   assign span    = j - b_i_ff;
   assign pal_bit = (sym_rd == sym_ff) && ((span <= IW'(1)) || pal_rd);
   assign cand    = (b_i_ff == '0) ? LW'(1) : parts_rd + LW'(1);
   assign pal_we  = b_valid_ff;

   // Cuts are parts minus one, saturated to the result width.
   assign cuts_raw = best_ff - LW'(1);
   assign cuts_ext = CW'(cuts_raw);
   assign cuts_sat = (cuts_ext > CW'(pmc_pkg::CUTS_MAX)) ? pmc_pkg::CUTS_MAX
                                                         : cuts_ext[pmc_pkg::CUTS_W-1:0];

   assign rsp.prefix_min_cuts = tl_ff ? held_ff : cuts_sat;
   assign rsp.end_of_string   = last_ff;
   assign rsp.too_long        = tl_ff;
   assign b_valid_in          = rd_en;

   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      held_in      = held_ff;
      sym_in       = sym_ff;
      last_in      = last_ff;
      tl_in        = tl_ff;
      i_in         = i_ff;
      best_in      = best_ff;
      rd_en        = 1'b0;
      sym_we       = 1'b0;
      parts_we     = 1'b0;
      ctl.cmd_pop  = 1'b0;
      ctl.rsp_push = 1'b0;
      unique case (state_ff)
         pmc_pkg::BK_IDLE: begin
            if (!q_status.cmd_empty) begin
               ctl.cmd_pop = 1'b1;
               sym_in      = cmd.symbol;
               last_in     = cmd.last;
               tl_in       = cmd.too_long;
               if (cmd.too_long) begin
                  state_in = pmc_pkg::BK_FINISH;
               end else begin
                  sym_we   = 1'b1;
                  i_in     = '0;
                  best_in  = len_ff + LW'(1);
                  state_in = pmc_pkg::BK_SWEEP;
               end
            end
         end
         pmc_pkg::BK_SWEEP: begin
            rd_en = 1'b1;
            i_in  = i_ff + IW'(1);
            if (i_ff == j) begin
               state_in = pmc_pkg::BK_DRAIN;
            end
         end
         pmc_pkg::BK_DRAIN: begin
            state_in = pmc_pkg::BK_FINISH;
         end
         pmc_pkg::BK_FINISH: begin
            if (!q_status.rsp_full) begin
               ctl.rsp_push = 1'b1;
               if (!tl_ff) begin
                  parts_we = 1'b1;
                  held_in  = cuts_sat;
                  len_in   = len_ff + LW'(1);
               end
               if (last_ff) begin
                  len_in  = '0;
                  held_in = '0;
               end
               state_in = pmc_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = pmc_pkg::BK_IDLE;
         end
      endcase
      // Lower the part count through every palindrome ending here.
      if (b_valid_ff && pal_bit && (cand < best_ff)) begin
         best_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pmc_pkg::BK_IDLE;
         len_ff     <= '0;
         held_ff    <= '0;
         b_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         len_ff     <= len_in;
         held_ff    <= held_in;
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff  <= sym_in;
      last_ff <= last_in;
      tl_ff   <= tl_in;
      i_ff    <= i_in;
      best_ff <= best_in;
      b_i_ff  <= i_ff;
   end

endmodule

>>> hdl/palindrome_min_cut_core.sv
// Palindrome min-cut core: queue-style top level with front end, back end and queues.
// Flow: a symbol passes the command queue, then the back end's idle, sweep, drain and
//   finish states, then the result queue; an overlong symbol skips sweep and drain.
// Order: the back end takes one symbol at a time and sweeps the stored prefix for it
//   through single read ports of its RAMs; later symbols wait in the command queue.
// Reset: synchronous, active high; clears queues, length counters and the sequencer.
//   RAM contents are not cleared: a fill count marks what is valid, so no clearing pass.
module palindrome_min_cut_core #(
   parameter int MAX_LEN     = pmc_pkg::PMC_MAX_LEN,
   parameter int QUEUE_DEPTH = pmc_pkg::PMC_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   // request side
   input  logic                        req_push,
   output logic                        req_full,
   input  logic [pmc_pkg::SYM_W-1:0]   req_symbol,
   input  logic                        req_last,
   // response side
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [pmc_pkg::CUTS_W-1:0]  rsp_prefix_min_cuts,
   output logic                        rsp_end_of_string,
   output logic                        rsp_too_long
);

   localparam int CMD_W = $bits(pmc_pkg::cmd_type);
   localparam int RSP_W = $bits(pmc_pkg::rsp_type);

   pmc_pkg::cmd_type          front_cmd, back_cmd;
   pmc_pkg::rsp_type          back_rsp, out_rsp;
   pmc_pkg::queue_status_type q_status;
   pmc_pkg::back_ctl_type     back_ctl;

   logic             front_push;
   logic             cmd_q_full, cmd_q_empty, rsp_q_full, rsp_q_empty;
   logic [CMD_W-1:0] cmd_wr_vec, cmd_rd_vec;
   logic [RSP_W-1:0] rsp_wr_vec, rsp_rd_vec;

   // Front end: count held symbols and classify each request before queuing it.
   pmc_front #(.MAX_LEN(MAX_LEN)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .queue_full (cmd_q_full),
      .symbol     (req_symbol),
      .last       (req_last),
      .cmd_push   (front_push),
      .cmd        (front_cmd)
   );

   assign req_full   = cmd_q_full;
   assign cmd_wr_vec = front_cmd;

   // Command queue: decouple acceptance from the long sweep.
   pmc_fifo #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (front_push),
      .wr_data (cmd_wr_vec),
      .full    (cmd_q_full),
      .pop     (back_ctl.cmd_pop),
      .rd_data (cmd_rd_vec),
      .empty   (cmd_q_empty)
   );

   assign back_cmd           = pmc_pkg::cmd_type'(cmd_rd_vec);
   assign q_status.cmd_empty = cmd_q_empty;
   assign q_status.rsp_full  = rsp_q_full;

   // Back end: run the palindrome sweep and produce one result per request.
   pmc_back #(.MAX_LEN(MAX_LEN)) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .cmd      (back_cmd),
      .ctl      (back_ctl),
      .rsp      (back_rsp)
   );

   assign rsp_wr_vec = back_rsp;

   // Result queue: hold finished results while the consumer stalls.
   pmc_fifo #(.WIDTH(RSP_W), .DEPTH(QUEUE_DEPTH)) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (back_ctl.rsp_push),
      .wr_data (rsp_wr_vec),
      .full    (rsp_q_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd_vec),
      .empty   (rsp_q_empty)
   );

   assign out_rsp             = pmc_pkg::rsp_type'(rsp_rd_vec);
   assign rsp_empty           = rsp_q_empty;
   assign rsp_prefix_min_cuts = out_rsp.prefix_min_cuts;
   assign rsp_end_of_string   = out_rsp.end_of_string;
   assign rsp_too_long        = out_rsp.too_long;

`ifndef SYNTHESIS
   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      back_ctl.rsp_push |-> !rsp_q_full)
      else $error("back end pushed a result into a full result queue");

   a_cmd_avail: assert property (@(posedge clock) disable iff (reset)
      back_ctl.cmd_pop |-> !cmd_q_empty)
      else $error("back end popped an empty command queue");

   a_pop_push_excl: assert property (@(posedge clock) disable iff (reset)
      $onehot0({back_ctl.cmd_pop, back_ctl.rsp_push}))
      else $error("back end took a request while delivering a result");
`endif

endmodule

>>> tb/tb_palindrome_min_cut_core.sv
// Self-checking testbench for the palindrome min-cut core.
module tb_palindrome_min_cut_core;

   localparam int SYM_W          = pmc_pkg::SYM_W;
   localparam int CUTS_W         = pmc_pkg::CUTS_W;
   localparam int PMC_MAX_LEN    = pmc_pkg::PMC_MAX_LEN;
   localparam logic [CUTS_W-1:0] CUTS_MAX = pmc_pkg::CUTS_MAX;

   localparam int CLK_PERIOD     = 10;
   localparam int TIMEOUT_CYCLES = 10_000_000;
   localparam int RANDOM_ITEMS   = 580;
   localparam int CALM_ITEMS     = 100;   // last random requests go without idling
   localparam int LONG_HOLD      = 400;   // receiver hold-off, in cycles
   localparam int SETTLE_CYCLES  = 50;
   localparam int MAX_REPORTS    = 10;

   // One row of the directed part. Rows with typed set carry their own expected
   // response; the others are checked against the predictor.
   typedef struct packed {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             typed;
      pmc_pkg::rsp_type rsp;
   } dir_row_type;

   localparam int DIR_ROWS = 25;
   localparam dir_row_type DIRECTED_ROWS [DIR_ROWS] = '{
      // single symbols straight after reset, both extremes
      '{8'h00, 1'b1, 1'b1, '{10'd0, 1'b1, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, '{10'd0, 1'b1, 1'b0}},
      // odd palindrome across the extremes: one cut, then none
      '{8'h00, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b0}},
      '{8'hFF, 1'b0, 1'b1, '{10'd1, 1'b0, 1'b0}},
      '{8'h00, 1'b1, 1'b1, '{10'd0, 1'b1, 1'b0}},
      // matching ends around a non-palindrome inside: no saving
      '{8'h61, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b0}},
      '{8'h62, 1'b0, 1'b1, '{10'd1, 1'b0, 1'b0}},
      '{8'h63, 1'b0, 1'b1, '{10'd2, 1'b0, 1'b0}},
      '{8'h61, 1'b1, 1'b1, '{10'd3, 1'b1, 1'b0}},
      // run of one symbol stays one palindrome
      '{8'h7A, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b0}},
      '{8'h7A, 1'b0, 1'b1, '{10'd0, 1'b0, 1'b0}},
      '{8'h7A, 1'b1, 1'b1, '{10'd0, 1'b1, 1'b0}},
      // even palindrome
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h61, 1'b1, 1'b0, '0},
      // short palindrome at the front only
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'h7F, 1'b1, 1'b0, '0},
      // overlapping palindromes
      '{8'h62, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h6E, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h6E, 1'b0, 1'b0, '0},
      '{8'h61, 1'b1, 1'b0, '0}
   };

   logic              clock = 1'b0;
   logic              reset;
   logic              req_push;
   logic              req_full;
   logic [SYM_W-1:0]  req_symbol;
   logic              req_last;
   logic              rsp_empty;
   logic              rsp_pop;
   logic [CUTS_W-1:0] rsp_prefix_min_cuts;
   logic              rsp_end_of_string;
   logic              rsp_too_long;

   // Predictor state: symbols of the current string, palindrome flags for the
   // latest position, least part count of every prefix, and the held length.
   logic [SYM_W-1:0] symbol_hist [PMC_MAX_LEN];
   bit               pal_flags   [PMC_MAX_LEN];
   int unsigned      least_parts [PMC_MAX_LEN+1];
   int unsigned      held_count;

   pmc_pkg::rsp_type pending_cuts [$];   // expected responses, oldest first
   int      error_count = 0;
   int      items_sent  = 0;
   bit      calm_mode   = 1'b0; // no idling on either side
   bit      hold_rsp    = 1'b0; // ask the receiver for a long hold-off
   bit      checking    = 1'b0;

   palindrome_min_cut_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_symbol          (req_symbol),
      .req_last            (req_last),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_prefix_min_cuts (rsp_prefix_min_cuts),
      .rsp_end_of_string   (rsp_end_of_string),
      .rsp_too_long        (rsp_too_long)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // Return the predictor to the empty-string state.
   function automatic void clear_string();
      for (int k = 0; k < PMC_MAX_LEN; k++) begin
         symbol_hist[k] = '0;
         pal_flags[k]   = 1'b0;
      end
      for (int k = 0; k <= PMC_MAX_LEN; k++) begin
         least_parts[k] = k;
      end
      held_count = 0;
   endfunction

   // Compute the response to one accepted request and advance the predictor.
   function automatic pmc_pkg::rsp_type predict_min_cuts(logic [SYM_W-1:0] sym, logic lst);
      pmc_pkg::rsp_type r;
      int unsigned j;
      int unsigned best;
      int unsigned cuts;
      bit          pal;
      r.too_long = 1'b0;
      if (held_count >= PMC_MAX_LEN) begin
         // string full: drop the symbol, repeat the held cuts
         r.too_long = 1'b1;
      end else begin
         j    = held_count;
         best = j + 1;
         symbol_hist[j] = sym;
         // ascending start: flag k+1 still describes the previous end position
         for (int unsigned k = 0; k <= j; k++) begin
            pal = 1'b0;
            if (symbol_hist[k] == sym) begin
               pal = (j - k < 2) ? 1'b1 : pal_flags[k+1];
            end
            pal_flags[k] = pal;
            if (pal && least_parts[k] + 1 < best) begin
               best = least_parts[k] + 1;
            end
         end
         least_parts[j+1] = best;
         held_count       = j + 1;
      end
      cuts = (held_count == 0) ? 0 : least_parts[held_count] - 1;
      r.prefix_min_cuts = (cuts > CUTS_MAX) ? CUTS_MAX : cuts[CUTS_W-1:0];
      r.end_of_string   = lst;
      if (lst) begin
         clear_string();
      end
      return r;
   endfunction

   // Idle the sender for a short random burst now and then.
   task automatic sender_gap();
      if (!calm_mode && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   // Offer one request, hold it until accepted, then log its expected response.
   // Leave req_push high afterwards unless the sender idles, so back-to-back requests need no toggle.
   task automatic push_symbol(input logic [SYM_W-1:0] sym, input logic lst,
                              input bit typed, input pmc_pkg::rsp_type typed_rsp);
      pmc_pkg::rsp_type predicted;
      req_push   <= 1'b1;
      req_symbol <= sym;
      req_last   <= lst;
      do @(posedge clock); while (req_full);
      predicted = predict_min_cuts(sym, lst);
      pending_cuts.push_back(typed ? typed_rsp : predicted);
      items_sent++;
      sender_gap();
   endtask

   // Stop offering and wait until every expected response has come back.
   task automatic drain_responses();
      req_push <= 1'b0;
      while (pending_cuts.size() != 0) @(posedge clock);
   endtask

   // Receiver: pop in random bursts, honor the long hold-off request, and pop
   // every cycle once the run is calm. Count the hold-off here, not in the sender.
   initial begin
      rsp_pop <= 1'b0;
      @(negedge reset);
      forever begin
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
         end else if (!calm_mode && $urandom_range(0, 9) < 3) begin
            rsp_pop <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_pop <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Compare every accepted response with the oldest expectation.
   always @(posedge clock) begin : check_rsp
      pmc_pkg::rsp_type want;
      if (checking && rsp_pop && !rsp_empty) begin
         if (pending_cuts.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
               $display("[%0t] unexpected response: cuts=%0d eos=%0b too_long=%0b",
                        $time, rsp_prefix_min_cuts, rsp_end_of_string, rsp_too_long);
            end
         end else begin
            want = pending_cuts.pop_front();
            if (want.prefix_min_cuts !== rsp_prefix_min_cuts ||
                want.end_of_string   !== rsp_end_of_string ||
                want.too_long        !== rsp_too_long) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("[%0t] mismatch (exp/got): cuts %0d/%0d eos %0b/%0b tl %0b/%0b",
                           $time, want.prefix_min_cuts, rsp_prefix_min_cuts,
                           want.end_of_string, rsp_end_of_string,
                           want.too_long, rsp_too_long);
               end
            end
         end
      end
   end

   // Main stimulus: directed rows, one string run past its length limit,
   // then random strings with random idling and the pressure points.
   initial begin : stimulus
      logic [SYM_W-1:0] str_buf [256];
      logic [SYM_W-1:0] alpha [3];
      logic [SYM_W-1:0] fill_syms [3];
      int               len;
      int               pick;
      int               alpha_n;
      int               string_idx;
      int               random_start;

      reset      <= 1'b1;
      req_push   <= 1'b0;
      req_symbol <= '0;
      req_last   <= 1'b0;
      clear_string();
      repeat (3) @(posedge clock);
      reset    <= 1'b0;
      checking = 1'b1;

      // Directed part: walk the table.
      for (int r = 0; r < DIR_ROWS; r++) begin
         push_symbol(DIRECTED_ROWS[r].symbol, DIRECTED_ROWS[r].last,
                     DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].rsp);
      end
      drain_responses();

      // Fill the string to its limit with a pattern that has no palindrome
      // longer than one symbol, so the cuts climb to the saturation value.
      // Then offer two more symbols: both must be dropped and flagged.
      fill_syms = '{8'h00, 8'hFF, 8'h5A};
      for (int k = 0; k < PMC_MAX_LEN; k++) begin
         push_symbol(fill_syms[k % 3], 1'b0, 1'b0, '0);
      end
      push_symbol(8'h5A, 1'b0, 1'b1, '{CUTS_MAX, 1'b0, 1'b1});
      push_symbol(8'h00, 1'b1, 1'b1, '{CUTS_MAX, 1'b1, 1'b1});
      drain_responses();

      // Random part: mostly short strings, a few long ones, all terminated.
      random_start = items_sent;
      string_idx   = 0;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            len = $urandom_range(1, 12);
         end else if (pick < 97) begin
            len = $urandom_range(13, 60);
         end else begin
            len = $urandom_range(61, 180);
         end
         alpha_n = $urandom_range(1, 3);
         for (int a = 0; a < 3; a++) begin
            alpha[a] = SYM_W'($urandom_range(0, 255));
         end
         pick = $urandom_range(0, 3);
         for (int k = 0; k < len; k++) begin
            case (pick)
               0: begin
                  str_buf[k] = SYM_W'($urandom_range(0, 255));
               end
               1, 2: begin
                  str_buf[k] = alpha[$urandom_range(0, alpha_n - 1)];
               end
               default: begin
                  // mirror the first half, with a rare flaw
                  if (k < (len + 1) / 2 || $urandom_range(0, 15) == 0) begin
                     str_buf[k] = alpha[$urandom_range(0, alpha_n - 1)];
                  end else begin
                     str_buf[k] = str_buf[len - 1 - k];
                  end
               end
            endcase
         end

         // pressure: stall the receiver while strings keep coming
         if (string_idx == 12) begin
            hold_rsp = 1'b1;
         end
         // pressure: let the block run dry before the next string
         if (string_idx == 5 || (string_idx != 12 && $urandom_range(0, 24) == 0)) begin
            drain_responses();
         end
         if (items_sent - random_start >= RANDOM_ITEMS - CALM_ITEMS) begin
            calm_mode = 1'b1;
         end

         for (int k = 0; k < len; k++) begin
            push_symbol(str_buf[k], (k == len - 1), 1'b0, '0);
         end
         string_idx++;
      end

      // Drain, then give stray responses a chance to show up.
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Stop a hung run.
   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
